// ----- rtl/mso_pkg.sv -----
package mso_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] count;
    logic [3:0]  slot_in;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] slot_out;
    logic [2:0] status;
    logic       last;
  } out_t;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_CANCEL  = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_CANCELED = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_FREE   = 3'd1;
  localparam logic [2:0] STAT_INVALID   = 3'd2;
  localparam logic [2:0] STAT_CANCELED  = 3'd3;
  localparam logic [2:0] STAT_FINISHED  = 3'd4;
  localparam logic [2:0] STAT_RUNNING   = 3'd5;
  localparam logic [2:0] STAT_ZERO      = 3'd6;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [4:0] MAX_REPORTS = 5'd16;

endpackage

// ----- rtl/multi_slot_oneshot_timer.sv -----
// Multi-slot one-shot countdown timer.
// The input channel carries one operation per transaction: tick, add, cancel
// or release. The output channel carries result transactions; the last one
// caused by an input has its last bit set. A tick whose slots do not expire
// gives no result at all.
// The slots live in a ring of identical cells. Each accepted transaction
// rotates the ring once; the entry at the head is examined and rewritten into
// the tail, so every slot passes the head once in slot order.
// An item is accepted in the idle state, then the ring rotates through every
// slot in the pass state, and the flush state hands over the final result.
// Input ready is high only while the block is idle, so no new item is taken
// before the last one is through. When the receiver stalls, the rotation
// pauses at the next expiry that must be handed on, and the output register
// holds its transaction. Reset marks every slot free and leaves no result pending.
module multi_slot_oneshot_timer #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mso_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mso_pkg::out_t  out_data_o
);

  import mso_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_FLUSH
  } state_e;

  state_e                state_q;
  in_t                   req_q;
  logic [COUNT_BITS-1:0] cnt_val_q;
  logic [IDX_W-1:0]      idx_q;
  logic [4:0]            found_q;
  logic                  pend_valid_q;
  out_t                  pend_q;
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  used_c  [SLOTS];
  logic [1:0]            state_c [SLOTS];
  logic [COUNT_BITS-1:0] rem_c   [SLOTS];

  logic                  h_used;
  logic [1:0]            h_state;
  logic [COUNT_BITS-1:0] h_rem;
  logic                  w_used;
  logic [1:0]            w_state;
  logic [COUNT_BITS-1:0] w_rem;

  logic                  match;
  logic                  set_pend;
  logic                  push;
  logic                  out_free;
  logic                  step;
  logic                  shift;
  out_t                  new_pend;
  logic [COUNT_BITS-1:0] in_cnt;
  logic                  out_load;
  out_t                  out_next;

  assign h_used  = used_c[0];
  assign h_state = state_c[0];
  assign h_rem   = rem_c[0];

  assign in_cnt   = COUNT_BITS'(in_data_i.count);
  assign match    = 32'(idx_q) == 32'(req_q.slot_in);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    w_used   = h_used;
    w_state  = h_state;
    w_rem    = h_rem;
    set_pend = 1'b0;
    push     = 1'b0;
    new_pend = '{kind: KIND_ANSWER, slot_out: 4'(idx_q), status: STAT_OK, last: 1'b1};
    case (req_q.operation)
      OP_TICK: begin
        if (h_used && h_state == ST_RUNNING) begin
          w_rem = h_rem - COUNT_BITS'(1);
          if (w_rem == '0) begin
            w_state = ST_FINISHED;
            if (found_q < MAX_REPORTS) begin
              set_pend      = 1'b1;
              push          = pend_valid_q;
              new_pend.kind = KIND_EXPIRY;
              new_pend.last = 1'b0;
            end
          end
        end
      end
      OP_ADD: begin
        if (cnt_val_q != '0 && found_q == '0 && !h_used) begin
          w_used   = 1'b1;
          w_state  = ST_RUNNING;
          w_rem    = cnt_val_q;
          set_pend = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (match && h_used) begin
          set_pend = 1'b1;
          if (h_state == ST_CANCELED) begin
            new_pend.status = STAT_CANCELED;
          end else if (h_state == ST_FINISHED) begin
            new_pend.status = STAT_FINISHED;
          end else begin
            w_state = ST_CANCELED;
          end
        end
      end
      default: begin
        if (match && h_used) begin
          set_pend = 1'b1;
          if (h_state == ST_RUNNING) begin
            new_pend.status = STAT_RUNNING;
          end else begin
            w_used = 1'b0;
          end
        end
      end
    endcase
  end

  assign step  = !push || out_free;
  assign shift = (state_q == S_PASS) && step;

  always_comb begin
    out_load = 1'b0;
    out_next = pend_q;
    if (state_q == S_PASS) begin
      out_load = step && push;
    end else if (state_q == S_FLUSH) begin
      out_load      = pend_valid_q && out_free;
      out_next.last = 1'b1;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic                  nb_used;
    logic [1:0]            nb_state;
    logic [COUNT_BITS-1:0] nb_rem;

    if (g == SLOTS - 1) begin : g_tail
      assign nb_used  = w_used;
      assign nb_state = w_state;
      assign nb_rem   = w_rem;
    end else begin : g_body
      assign nb_used  = used_c[g+1];
      assign nb_state = state_c[g+1];
      assign nb_rem   = rem_c[g+1];
    end

    mso_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .used_i (nb_used),
      .state_i(nb_state),
      .rem_i  (nb_rem),
      .used_o (used_c[g]),
      .state_o(state_c[g]),
      .rem_o  (rem_c[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      cnt_val_q    <= '0;
      idx_q        <= '0;
      found_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_load) begin
        out_q       <= out_next;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q        <= in_data_i;
            cnt_val_q    <= in_cnt;
            idx_q        <= '0;
            found_q      <= '0;
            pend_valid_q <= in_data_i.operation != OP_TICK;
            if (in_data_i.operation == OP_ADD) begin
              pend_q <= '{kind: KIND_ANSWER, slot_out: 4'd0,
                          status: (in_cnt == '0) ? STAT_ZERO : STAT_NO_FREE, last: 1'b1};
            end else begin
              pend_q <= '{kind: KIND_ANSWER, slot_out: in_data_i.slot_in,
                          status: STAT_INVALID, last: 1'b1};
            end
            state_q <= S_PASS;
          end
        end
        S_PASS: begin
          if (step) begin
            if (set_pend) begin
              pend_q       <= new_pend;
              pend_valid_q <= 1'b1;
              if (found_q < MAX_REPORTS) begin
                found_q <= found_q + 5'd1;
              end
            end
            idx_q <= idx_q + IDX_W'(1);
            if (idx_q == IDX_W'(SLOTS - 1)) begin
              state_q <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/mso_cell.sv -----
module mso_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  used_i,
  input  logic [1:0]            state_i,
  input  logic [COUNT_BITS-1:0] rem_i,
  output logic                  used_o,
  output logic [1:0]            state_o,
  output logic [COUNT_BITS-1:0] rem_o
);

  logic                  used_q;
  logic [1:0]            state_q;
  logic [COUNT_BITS-1:0] rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= used_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      state_q <= state_i;
      rem_q   <= rem_i;
    end
  end

  assign used_o  = used_q;
  assign state_o = state_q;
  assign rem_o   = rem_q;

endmodule
